@@ hdl/two_table_score_calibrator_defines.svh @@
// Assertion macros shared by the calibrator RTL.
`ifndef TWO_TABLE_SCORE_CALIBRATOR_DEFINES_SVH
`define TWO_TABLE_SCORE_CALIBRATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TTSC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ttsc same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define TTSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ttsc next-cycle check failed");

`endif

@@ hdl/ttsc_pkg.sv @@
// Types and constants of the two-table score calibrator.
package ttsc_pkg;

   localparam int unsigned KEY_W   = 32;
   localparam int unsigned LEVEL_W = 23;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned INDEX_W = 6;
   localparam logic [LEVEL_W-1:0] TOP_SCORE = 23'd6553600;

   typedef enum logic [1:0] {
      MODE_LOAD_FIRST  = 2'd0,
      MODE_LOAD_SECOND = 2'd1,
      MODE_QUERY       = 2'd2,
      MODE_UNUSED      = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_SPLIT_BOUND  = 2'd0,
      CSR_SPLIT_LEVEL  = 2'd1,
      CSR_FIRST_COUNT  = 2'd2,
      CSR_SECOND_COUNT = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      logic [1:0]                mode;
      logic [INDEX_W-1:0]        entry_index;
      logic signed [KEY_W-1:0]   entry_key;
      logic [LEVEL_W-1:0]        entry_level;
      logic signed [KEY_W-1:0]   first_pred;
      logic signed [KEY_W-1:0]   second_pred;
      logic                      last_query;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] score;
      logic               used_second;
      logic               last_result;
   } rsp_type;

   // One classified item waiting for the back end.
   typedef struct packed {
      op_type                    op;
      logic                      second;
      logic [INDEX_W-1:0]        index;
      logic signed [KEY_W-1:0]   key;
      logic [LEVEL_W-1:0]        level;
      logic signed [KEY_W-1:0]   pred;
      logic [LEVEL_W-1:0]        upper;
      logic [LEVEL_W-1:0]        lower;
      logic [COUNT_W-1:0]        count;
      logic                      last;
   } job_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [LEVEL_W-1:0]      level;
   } entry_type;

endpackage

@@ hdl/ttsc_front.sv @@
// Front end: configuration registers, item classification and table choice.
module ttsc_front #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   input  logic              accept,
   input  ttsc_pkg::req_type req_item,
   output logic              push,
   output ttsc_pkg::job_type job
);

   logic signed [31:0] split_bound_ff, split_bound_in;
   logic [22:0]        split_level_ff, split_level_in;
   logic [6:0]         first_count_ff, first_count_in;
   logic [6:0]         second_count_ff, second_count_in;
   logic [6:0]         first_sat, second_sat;
   logic               load_ok;
   logic               is_load, is_query;

   always_comb begin
      split_bound_in  = split_bound_ff;
      split_level_in  = split_level_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      if (csr_we) begin
         unique case (ttsc_pkg::csr_index_type'(csr_index))
            ttsc_pkg::CSR_SPLIT_BOUND:  split_bound_in  = $signed(csr_wdata);
            ttsc_pkg::CSR_SPLIT_LEVEL:  split_level_in  = csr_wdata[22:0];
            ttsc_pkg::CSR_FIRST_COUNT:  first_count_in  = csr_wdata[6:0];
            ttsc_pkg::CSR_SECOND_COUNT: second_count_in = csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         split_bound_ff  <= '0;
         split_level_ff  <= '0;
         first_count_ff  <= '0;
         second_count_ff <= '0;
      end else begin
         split_bound_ff  <= split_bound_in;
         split_level_ff  <= split_level_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
      end
   end

   // Clamp counts to the table depth.
   assign first_sat  = (32'(first_count_ff) > 32'(TABLE_DEPTH)) ?
                       7'(TABLE_DEPTH) : first_count_ff;
   assign second_sat = (32'(second_count_ff) > 32'(TABLE_DEPTH)) ?
                       7'(TABLE_DEPTH) : second_count_ff;

   assign load_ok  = 32'(req_item.entry_index) < 32'(TABLE_DEPTH);
   assign is_load  = (req_item.mode == ttsc_pkg::MODE_LOAD_FIRST) ||
                     (req_item.mode == ttsc_pkg::MODE_LOAD_SECOND);
   assign is_query = req_item.mode == ttsc_pkg::MODE_QUERY;
   assign push     = accept && (is_query || (is_load && load_ok));

   always_comb begin
      job       = '0;
      job.index = req_item.entry_index;
      job.key   = req_item.entry_key;
      job.level = req_item.entry_level;
      job.last  = req_item.last_query;
      if (is_query) begin
         job.op = ttsc_pkg::OP_QUERY;
         if (req_item.first_pred >= split_bound_ff) begin
            job.second = 1'b0;
            job.pred   = req_item.first_pred;
            job.upper  = ttsc_pkg::TOP_SCORE;
            job.lower  = split_level_ff;
            job.count  = first_sat;
         end else begin
            job.second = 1'b1;
            job.pred   = req_item.second_pred;
            job.upper  = split_level_ff;
            job.lower  = '0;
            job.count  = second_sat;
         end
      end else begin
         job.op     = ttsc_pkg::OP_LOAD;
         job.second = req_item.mode == ttsc_pkg::MODE_LOAD_SECOND;
      end
   end

endmodule

@@ hdl/ttsc_queue.sv @@
// Two-entry queue between front and back end.
module ttsc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ttsc_pkg::job_type push_job,
   input  logic              pop,
   output logic              head_valid,
   output ttsc_pkg::job_type head_job,
   output logic              full,
   output logic [1:0]        fill
);

   ttsc_pkg::job_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign head_valid = count_ff != 2'd0;
   assign head_job   = slot_ff[rd_ptr_ff];
   assign full       = count_ff == 2'd2;
   assign fill       = count_ff;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hdl/ttsc_back.sv @@
// Back end: breakpoint tables, walk, interpolation and serial divider.
module ttsc_back #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  ttsc_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_strobe,
   output ttsc_pkg::rsp_type rsp_item
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int QW = ttsc_pkg::LEVEL_W;
   localparam logic [4:0] LAST_STEP = 5'(QW - 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_WALK = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_ADD  = 5'b01000,
      ST_DIV  = 5'b10000
   } state_type;

   ttsc_pkg::entry_type first_mem [TABLE_DEPTH];
   ttsc_pkg::entry_type second_mem [TABLE_DEPTH];
   ttsc_pkg::entry_type first_rd_ff, second_rd_ff, cur;

   state_type         state_ff, state_in;
   ttsc_pkg::job_type job_ff, job_in;
   logic [6:0]        idx_ff, idx_in;
   logic [6:0]        idx_next;
   logic signed [31:0] prev_key_ff, prev_key_in;
   logic [22:0]       prev_lvl_ff, prev_lvl_in;
   logic [22:0]       cur_lvl_ff, cur_lvl_in;
   logic [32:0]       hi_ff, hi_in, lo_ff, lo_in, den_ff, den_in;
   logic [55:0]       prod_ff, prod_in;
   logic [56:0]       num;
   logic [32:0]       rem_ff, rem_in;
   logic [QW-1:0]     quo_ff, quo_in;
   logic [4:0]        step_ff, step_in;
   logic [33:0]       trial;
   logic              rsp_valid_ff, rsp_valid_in;
   ttsc_pkg::rsp_type rsp_ff, rsp_in;
   logic [AW-1:0]     rd_addr;
   logic              wr_first, wr_second;
   logic [AW-1:0]     wr_addr;
   ttsc_pkg::entry_type wr_word;

   assign cur      = job_ff.second ? second_rd_ff : first_rd_ff;
   assign idx_next = idx_ff + 7'd1;
   assign num      = 57'(prod_ff) + 57'(lo_ff * cur_lvl_ff);
   assign trial    = {rem_ff, quo_ff[QW-1]};
   assign wr_addr  = AW'(head_job.index);
   assign wr_word  = '{key: head_job.key, level: head_job.level};

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      prev_key_in  = prev_key_ff;
      prev_lvl_in  = prev_lvl_ff;
      cur_lvl_in   = cur_lvl_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      den_in       = den_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_addr      = '0;
      pop          = 1'b0;
      wr_first     = 1'b0;
      wr_second    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               if (head_job.op == ttsc_pkg::OP_LOAD) begin
                  wr_first  = !head_job.second;
                  wr_second = head_job.second;
               end else begin
                  job_in = head_job;
                  if (head_job.count == 7'd0) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{score: head_job.upper, used_second: head_job.second,
                                last_result: head_job.last};
                  end else begin
                     idx_in   = '0;
                     state_in = ST_WALK;
                  end
               end
            end
         end
         ST_WALK: begin
            rsp_in.used_second = job_ff.second;
            rsp_in.last_result = job_ff.last;
            if (job_ff.pred < cur.key) begin
               // advance past this breakpoint
               prev_key_in = cur.key;
               prev_lvl_in = cur.level;
               if (idx_next == job_ff.count) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.score = job_ff.lower;
                  state_in     = ST_IDLE;
               end else begin
                  idx_in  = idx_next;
                  rd_addr = AW'(idx_next);
               end
            end else if (idx_ff == 7'd0) begin
               rsp_valid_in = 1'b1;
               rsp_in.score = job_ff.upper;
               state_in     = ST_IDLE;
            end else begin
               hi_in      = 33'({job_ff.pred[31], job_ff.pred} - {cur.key[31], cur.key});
               lo_in      = 33'({prev_key_ff[31], prev_key_ff} - {job_ff.pred[31], job_ff.pred});
               den_in     = 33'({prev_key_ff[31], prev_key_ff} - {cur.key[31], cur.key});
               cur_lvl_in = cur.level;
               if (prev_key_ff == cur.key) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.score = prev_lvl_ff;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = hi_ff * prev_lvl_ff;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            // quotient fits the level width, so the upper bits already lie below den
            rem_in   = num[55:QW];
            quo_in   = num[QW-1:0];
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = 33'(trial - {1'b0, den_ff});
               quo_in = {quo_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = trial[32:0];
               quo_in = {quo_ff[QW-2:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
            if (step_ff == LAST_STEP) begin
               rsp_valid_in = 1'b1;
               rsp_in.score = quo_in;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_first) first_mem[wr_addr] <= wr_word;
      if (wr_second) second_mem[wr_addr] <= wr_word;
      first_rd_ff  <= first_mem[rd_addr];
      second_rd_ff <= second_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      idx_ff      <= idx_in;
      prev_key_ff <= prev_key_in;
      prev_lvl_ff <= prev_lvl_in;
      cur_lvl_ff  <= cur_lvl_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      den_ff      <= den_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

@@ hdl/two_table_score_calibrator.sv @@
// Two-table score calibrator: the front classifies items into a two-entry queue,
// the back walks one breakpoint table per query and interpolates. A load is written
// to its table when the back end pops it. A query walks one breakpoint per cycle
// (up to the count in use), then does a multiply step, a multiply-add step and a
// bit-serial divide for the 23-bit quotient; the back end pops no new job until
// the query has finished. An empty table or an out-of-range prediction finishes
// without interpolating. The result beat is on rsp_item for one cycle with
// rsp_strobe and cannot be held off. busy is high while the queue is full.
`include "two_table_score_calibrator_defines.svh"

module two_table_score_calibrator #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ttsc_pkg::req_type req_item,
   output logic              rsp_strobe,
   output ttsc_pkg::rsp_type rsp_item,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   logic              accept, push, pop, head_valid, full;
   logic [1:0]        fill;
   ttsc_pkg::job_type push_job, head_job;

   assign accept = start && !busy;
   assign busy   = full;

   ttsc_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .accept, .req_item, .push, .job(push_job)
   );

   ttsc_queue u_queue (
      .clock, .reset, .push, .push_job, .pop,
      .head_valid, .head_job, .full, .fill
   );

   ttsc_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock, .reset, .head_valid, .head_job, .pop, .rsp_strobe, .rsp_item
   );

   `TTSC_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill != 2'd3)
   `TTSC_ASSERT_NEXT(a_push_lands, clock, reset, push, fill != 2'd0)
   `TTSC_ASSERT_NOW(a_pop_nonempty, clock, reset, pop, head_valid)

endmodule
